[design/sam_pkg.sv]
package sam_pkg;

    localparam int DOT_W      = 42;
    localparam int REFE_W     = 40;
    localparam int RECE_W     = 42;
    localparam int ASUM_W     = 46;
    localparam int CNT_W      = 23;
    localparam int ANG_W      = 24;
    localparam int REF_W      = 16;
    localparam int REC_W      = 17;
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = 2;
    localparam int CORDIC_N   = 27;
    localparam logic [ANG_W-1:0] ANGLE_MAX = 24'd11796480;

    typedef struct packed {
        logic signed [DOT_W-1:0]  dot;
        logic [REFE_W-1:0]        ref_e;
        logic [RECE_W-1:0]        rec_e;
        logic                     last_pixel;
    } t_pix;

    // arctan(2^-i) in degrees, Q20
    function automatic logic [25:0] atan_q20(input logic [4:0] idx);
        logic [25:0] v;
        unique case (idx)
            5'd0:  v = 26'd47185920;
            5'd1:  v = 26'd27855475;
            5'd2:  v = 26'd14718068;
            5'd3:  v = 26'd7471121;
            5'd4:  v = 26'd3750058;
            5'd5:  v = 26'd1876857;
            5'd6:  v = 26'd938658;
            5'd7:  v = 26'd469357;
            5'd8:  v = 26'd234682;
            5'd9:  v = 26'd117342;
            5'd10: v = 26'd58671;
            5'd11: v = 26'd29335;
            5'd12: v = 26'd14668;
            5'd13: v = 26'd7334;
            5'd14: v = 26'd3667;
            5'd15: v = 26'd1833;
            5'd16: v = 26'd917;
            5'd17: v = 26'd458;
            5'd18: v = 26'd229;
            5'd19: v = 26'd115;
            5'd20: v = 26'd57;
            5'd21: v = 26'd29;
            5'd22: v = 26'd14;
            5'd23: v = 26'd7;
            5'd24: v = 26'd4;
            5'd25: v = 26'd2;
            5'd26: v = 26'd1;
            default: v = 26'd0;
        endcase
        return v;
    endfunction

endpackage

[design/sam_front.sv]
module sam_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [sam_pkg::REF_W-1:0]   i_ref_value,
    input  logic [sam_pkg::REC_W-1:0]   i_rec_value,
    input  logic                        i_last_band,
    input  logic                        i_last_pixel,
    input  logic                        i_q_full,
    output logic                        o_push,
    output sam_pkg::t_pix               o_pix
);
    import sam_pkg::*;

    logic signed [DOT_W-1:0]  r_dot, n_dot;
    logic [REFE_W-1:0]        r_ref_e, n_ref_e;
    logic [RECE_W-1:0]        r_rec_e, n_rec_e;
    logic signed [REF_W+REC_W:0] prod_dot;
    logic [2*REF_W-1:0]       prod_ref;
    logic signed [2*REC_W-1:0] prod_rec;
    logic                     acc;

    assign o_ready  = !i_q_full;
    assign acc      = i_valid && !i_q_full;
    assign prod_dot = 34'(($signed({1'b0, i_ref_value}) * $signed(i_rec_value)));
    assign prod_ref = i_ref_value * i_ref_value;
    assign prod_rec = $signed(i_rec_value) * $signed(i_rec_value);

    always_comb begin
        n_dot   = r_dot + DOT_W'(prod_dot);
        n_ref_e = r_ref_e + REFE_W'(prod_ref);
        n_rec_e = r_rec_e + RECE_W'($unsigned(prod_rec));
    end

    assign o_push           = acc && i_last_band;
    assign o_pix.dot        = n_dot;
    assign o_pix.ref_e      = n_ref_e;
    assign o_pix.rec_e      = n_rec_e;
    assign o_pix.last_pixel = i_last_pixel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dot   <= '0;
            r_ref_e <= '0;
            r_rec_e <= '0;
        end else if (acc) begin
            if (i_last_band) begin
                r_dot   <= '0;
                r_ref_e <= '0;
                r_rec_e <= '0;
            end else begin
                r_dot   <= n_dot;
                r_ref_e <= n_ref_e;
                r_rec_e <= n_rec_e;
            end
        end
    end

endmodule

[design/sam_queue.sv]
module sam_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  sam_pkg::t_pix i_pix,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output sam_pkg::t_pix o_pix
);
    import sam_pkg::*;

    t_pix               r_mem [QDEPTH];
    logic [QPTR_W-1:0]  r_wp, r_rp;
    logic [QPTR_W:0]    r_cnt;

    assign o_full  = (r_cnt == (QPTR_W+1)'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_pix   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_pix;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            unique case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

[design/sam_back.sv]
module sam_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_empty,
    input  sam_pkg::t_pix               i_pix,
    output logic                        o_pop,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [sam_pkg::ANG_W-1:0]   o_pixel_angle,
    output logic [sam_pkg::ANG_W-1:0]   o_mean_angle,
    output logic                        o_mean_valid
);
    import sam_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_CHK, S_SQ1, S_SQ2, S_MUL, S_DIV0, S_DIV, S_COS,
        S_SINQ, S_CORD, S_FIN, S_ACC, S_MDIV, S_OUT
    } t_state;

    t_state                   r_state;
    t_pix                     r_pix;
    // shared integer square root
    logic [63:0]              r_sv, r_sr, r_sb;
    logic [63:0]              s_t;
    // shared restoring divider
    logic [63:0]              r_rem, r_num, r_den, r_q;
    logic [5:0]               r_dcnt;
    logic [64:0]              d_sh;
    logic [30:0]              r_n1;
    logic [31:0]              r_n2;
    logic [41:0]              r_a;
    logic [30:0]              r_cmag;
    logic                     r_neg;
    logic signed [33:0]       r_x, r_y;
    logic signed [31:0]       r_z;
    logic [4:0]               r_i;
    logic signed [33:0]       c_xs, c_ys;
    logic signed [31:0]       c_at;
    logic signed [32:0]       c_r;
    logic [ANG_W-1:0]         r_ang;
    logic [ASUM_W-1:0]        r_asum;
    logic [CNT_W-1:0]         r_cnt;

    assign s_t  = r_sr + r_sb;
    assign d_sh = {r_rem, r_num[63]};
    assign c_xs = r_x >>> r_i;
    assign c_ys = r_y >>> r_i;
    assign c_at = 32'(atan_q20(r_i));
    assign c_r  = (33'(r_z) + (r_neg ? 33'sd94371840 : 33'sd0) + 33'sd8) >>> 4;
    assign o_pop = (r_state == S_IDLE) && !i_q_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            o_valid      <= 1'b0;
            r_asum       <= '0;
            r_cnt        <= '0;
            r_sb         <= '0;
            r_dcnt       <= '0;
        end else begin
            if (o_valid && i_ready && r_state != S_OUT) o_valid <= 1'b0;

            // square-root step runs whenever a root is pending
            if (r_sb != '0) begin
                if (r_sv >= s_t) begin
                    r_sv <= r_sv - s_t;
                    r_sr <= (r_sr >> 1) + r_sb;
                end else begin
                    r_sr <= r_sr >> 1;
                end
                r_sb <= r_sb >> 2;
            end
            if (r_dcnt != '0) begin
                r_num  <= r_num << 1;
                r_dcnt <= r_dcnt - 1'b1;
                if (d_sh >= {1'b0, r_den}) begin
                    r_rem <= 64'(d_sh - {1'b0, r_den});
                    r_q   <= {r_q[62:0], 1'b1};
                end else begin
                    r_rem <= d_sh[63:0];
                    r_q   <= {r_q[62:0], 1'b0};
                end
            end

            unique case (r_state)
                S_IDLE: begin
                    r_sb   <= '0;
                    r_dcnt <= '0;
                    if (!i_q_empty) begin
                        r_pix   <= i_pix;
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    r_neg <= r_pix.dot[DOT_W-1];
                    r_a   <= r_pix.dot[DOT_W-1] ? 42'(-r_pix.dot) : r_pix.dot;
                    if (r_pix.ref_e == '0 || r_pix.rec_e == '0) begin
                        r_ang   <= '0;
                        r_state <= S_ACC;
                    end else begin
                        r_sv    <= {4'b0, r_pix.ref_e, 20'b0};
                        r_sr    <= '0;
                        r_sb    <= 64'h4000_0000_0000_0000;
                        r_state <= S_SQ1;
                    end
                end
                S_SQ1: if (r_sb == '0) begin
                    r_n1    <= r_sr[30:0];
                    r_sv    <= {2'b0, r_pix.rec_e, 20'b0};
                    r_sr    <= '0;
                    r_sb    <= 64'h4000_0000_0000_0000;
                    r_state <= S_SQ2;
                end
                S_SQ2: if (r_sb == '0) begin
                    r_n2    <= r_sr[31:0];
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_den   <= 64'(r_n1 * r_n2);
                    r_state <= S_DIV0;
                end
                S_DIV0: begin
                    if (r_den == '0) begin
                        r_ang   <= '0;
                        r_state <= S_ACC;
                    end else if ({22'b0, r_a} >= r_den) begin
                        r_cmag  <= 31'h4000_0000;
                        r_state <= S_COS;
                    end else begin
                        r_rem   <= {22'b0, r_a};
                        r_num   <= '0;
                        r_q     <= '0;
                        r_dcnt  <= 6'd50;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: if (r_dcnt == '0) begin
                    r_cmag  <= (r_q > 64'h4000_0000) ? 31'h4000_0000 : r_q[30:0];
                    r_state <= S_COS;
                end
                S_COS: begin
                    if (r_cmag[30]) begin
                        r_ang   <= r_neg ? ANGLE_MAX : '0;
                        r_state <= S_ACC;
                    end else begin
                        r_sv    <= 64'h1000_0000_0000_0000
                                   - 64'(r_cmag[29:0] * r_cmag[29:0]);
                        r_sr    <= '0;
                        r_sb    <= 64'h4000_0000_0000_0000;
                        r_state <= S_SINQ;
                    end
                end
                S_SINQ: if (r_sb == '0) begin
                    // negative cosine: rotate by -90 degrees first
                    if (r_neg) begin
                        r_x <= 34'(r_sr[31:0]);
                        r_y <= 34'(r_cmag);
                    end else begin
                        r_x <= 34'(r_cmag);
                        r_y <= 34'(r_sr[31:0]);
                    end
                    r_z     <= '0;
                    r_i     <= '0;
                    r_state <= S_CORD;
                end
                S_CORD: begin
                    if (r_y >= 0) begin
                        r_x <= r_x + c_ys;
                        r_y <= r_y - c_xs;
                        r_z <= r_z + c_at;
                    end else begin
                        r_x <= r_x - c_ys;
                        r_y <= r_y + c_xs;
                        r_z <= r_z - c_at;
                    end
                    r_i <= r_i + 1'b1;
                    if (r_i == 5'(CORDIC_N - 1)) r_state <= S_FIN;
                end
                S_FIN: begin
                    if (c_r < 0)
                        r_ang <= '0;
                    else if (c_r > $signed({9'b0, ANGLE_MAX}))
                        r_ang <= ANGLE_MAX;
                    else
                        r_ang <= c_r[ANG_W-1:0];
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_asum <= r_asum + ASUM_W'(r_ang);
                    if (r_cnt != '1) r_cnt <= r_cnt + 1'b1;
                    if (r_pix.last_pixel) begin
                        r_rem   <= '0;
                        r_num   <= {r_asum + ASUM_W'(r_ang), 18'b0};
                        r_den   <= 64'((r_cnt != '1) ? r_cnt + 1'b1 : r_cnt);
                        r_q     <= '0;
                        r_dcnt  <= 6'(ASUM_W);
                        r_state <= S_MDIV;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_MDIV: if (r_dcnt == '0) begin
                    r_asum  <= '0;
                    r_cnt   <= '0;
                    r_state <= S_OUT;
                end
                S_OUT: if (!o_valid || i_ready) begin
                    o_valid       <= 1'b1;
                    o_pixel_angle <= r_ang;
                    o_mean_valid  <= r_pix.last_pixel;
                    if (!r_pix.last_pixel)
                        o_mean_angle <= '0;
                    else if (r_q > 64'(ANGLE_MAX))
                        o_mean_angle <= ANGLE_MAX;
                    else
                        o_mean_angle <= r_q[ANG_W-1:0];
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

[design/spectral_angle_mapper.sv]
// channel  dir  handshake                       payload
// s_axis   in   i_s_axis_tvalid/o_s_axis_tready tdata ref,rec; tlast last band; tuser last pixel
// m_axis   out  o_m_axis_tvalid/i_m_axis_tready tdata pixel,mean angle; tuser mean valid
// Band items are taken one per cycle while the four-entry pixel queue has room.
// The back end works on one pixel at a time: up to three 32-step roots, a
// 50-step divide and 27 CORDIC steps (a zero vector skips them); the last pixel
// of an image adds the mean divide.
// Synchronous active-low reset clears accumulators, queue and sequencer.
// A stalled output holds the back end; the front stalls only on a full queue.
module spectral_angle_mapper (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,  // ref_value[15:0], rec_value[32:16], zero pad
    input  logic        i_s_axis_tlast,
    input  logic        i_s_axis_tuser,  // last_pixel
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,  // pixel_angle[23:0], mean_angle[47:24]
    output logic        o_m_axis_tuser   // mean_valid
);
    import sam_pkg::*;

    t_pix q_in, q_out;
    logic push, full, pop, empty;

    sam_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_axis_tvalid),
        .o_ready      (o_s_axis_tready),
        .i_ref_value  (i_s_axis_tdata[15:0]),
        .i_rec_value  (i_s_axis_tdata[32:16]),
        .i_last_band  (i_s_axis_tlast),
        .i_last_pixel (i_s_axis_tuser),
        .i_q_full     (full),
        .o_push       (push),
        .o_pix        (q_in)
    );

    sam_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pix   (q_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_pix   (q_out)
    );

    sam_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (empty),
        .i_pix         (q_out),
        .o_pop         (pop),
        .o_valid       (o_m_axis_tvalid),
        .i_ready       (i_m_axis_tready),
        .o_pixel_angle (o_m_axis_tdata[23:0]),
        .o_mean_angle  (o_m_axis_tdata[47:24]),
        .o_mean_valid  (o_m_axis_tuser)
    );

endmodule

[dv/tb.sv]
module tb;
    import sam_pkg::*;

    localparam int WDOG_LIMIT = 6000;
    localparam int N_ITEMS    = 1450;
    localparam int QUIET_FROM = 1300;

    typedef struct {
        logic [ANG_W-1:0] pixel_angle;
        logic [ANG_W-1:0] mean_angle;
        logic             mean_valid;
    } t_angles;

    // arctan(2^-i) in degrees, Q20
    localparam longint ATAN_Q20 [CORDIC_N] = '{
        47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658,
        469357, 234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833, 917,
        458, 229, 115, 57, 29, 14, 7, 4, 2, 1};

    class angle_scoreboard;
        logic [DOT_W-1:0]  dot;
        logic [REFE_W-1:0] ref_e;
        logic [RECE_W-1:0] rec_e;
        logic [ASUM_W-1:0] angle_sum;
        logic [CNT_W-1:0]  pix_cnt;
        t_angles           pending_q[$];
        int                errors;
        int                n_items;
        int                n_results;
        int                n_images;

        function new();
            dot = '0; ref_e = '0; rec_e = '0; angle_sum = '0; pix_cnt = '0;
            errors = 0; n_items = 0; n_results = 0; n_images = 0;
        endfunction

        function longint unsigned isqrt(longint unsigned v);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v) b >>= 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v -= r + b;
                    r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return r;
        endfunction

        // cosine Q1.30 to degrees Q8.16
        function logic [ANG_W-1:0] acos_q16(longint c);
            longint x, y, z, off, nx, ny, r;
            longint unsigned cc;
            z = 0;
            off = 0;
            if (c >= (64'sd1 <<< 30)) return '0;
            if (c <= -(64'sd1 <<< 30)) return ANGLE_MAX;
            cc = (c < 0) ? -c : c;
            y = isqrt((64'd1 << 60) - cc * cc);
            x = c;
            if (x < 0) begin
                nx = y; y = -x; x = nx; off = 64'sd90 <<< 20;
            end
            for (int i = 0; i < CORDIC_N; i++) begin
                if (y >= 0) begin
                    nx = x + (y >>> i); ny = y - (x >>> i); z += ATAN_Q20[i];
                end else begin
                    nx = x - (y >>> i); ny = y + (x >>> i); z -= ATAN_Q20[i];
                end
                x = nx; y = ny;
            end
            r = (z + off + 8) >>> 4;
            if (r < 0) r = 0;
            if (r > longint'(ANGLE_MAX)) r = ANGLE_MAX;
            return r[ANG_W-1:0];
        endfunction

        function logic [ANG_W-1:0] pixel_angle();
            longint d, c;
            longint unsigned n1, n2, den, a, rem, q;
            d = $signed(dot);
            q = 0;
            if (ref_e == 0 || rec_e == 0) return '0;
            n1 = isqrt(64'(ref_e) << 20);
            n2 = isqrt(64'(rec_e) << 20);
            den = n1 * n2;
            if (den == 0) return '0;
            a = (d < 0) ? -d : d;
            if (a >= den) begin
                q = 64'd1 << 30;
            end else begin
                rem = a;
                for (int i = 0; i < 50; i++) begin
                    rem <<= 1;
                    q <<= 1;
                    if (rem >= den) begin
                        rem -= den;
                        q |= 1;
                    end
                end
                if (q > (64'd1 << 30)) q = 64'd1 << 30;
            end
            c = (d < 0) ? -longint'(q) : longint'(q);
            return acos_q16(c);
        endfunction

        function void note_item(logic [REF_W-1:0] rv, logic signed [REC_W-1:0] sv,
                                logic lb, logic lp);
            longint unsigned su, prod, mean;
            t_angles e;
            n_items++;
            su = (sv < 0) ? -longint'(sv) : longint'(sv);
            prod = 64'(rv) * su;
            if (sv < 0) dot = dot - prod[DOT_W-1:0];
            else dot = dot + prod[DOT_W-1:0];
            ref_e = ref_e + REFE_W'(64'(rv) * 64'(rv));
            rec_e = rec_e + RECE_W'(su * su);
            if (!lb) return;
            e.pixel_angle = pixel_angle();
            e.mean_angle = '0;
            e.mean_valid = 1'b0;
            angle_sum = angle_sum + e.pixel_angle;
            if (pix_cnt != '1) pix_cnt++;
            dot = '0; ref_e = '0; rec_e = '0;
            if (lp) begin
                mean = 64'(angle_sum) / 64'(pix_cnt);
                if (mean > ANGLE_MAX) mean = ANGLE_MAX;
                e.mean_angle = mean[ANG_W-1:0];
                e.mean_valid = 1'b1;
                angle_sum = '0;
                pix_cnt = '0;
                n_images++;
            end
            pending_q.push_back(e);
        endfunction

        function void check_result(logic [47:0] data, logic user);
            t_angles e;
            n_results++;
            if (pending_q.size() == 0) begin
                $error("unexpected result: pixel_angle %0d", data[23:0]);
                errors++;
                return;
            end
            e = pending_q.pop_front();
            if (data[23:0] !== e.pixel_angle) begin
                $error("pixel_angle: expected %0d, got %0d", e.pixel_angle, data[23:0]);
                errors++;
            end
            if (data[47:24] !== e.mean_angle) begin
                $error("mean_angle: expected %0d, got %0d", e.mean_angle, data[47:24]);
                errors++;
            end
            if (user !== e.mean_valid) begin
                $error("mean_valid: expected %0d, got %0d", e.mean_valid, user);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [39:0] i_s_axis_tdata;  // ref_value[15:0], rec_value[32:16], zero pad
    logic        i_s_axis_tlast;
    logic        i_s_axis_tuser;  // last_pixel
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [47:0] o_m_axis_tdata;  // pixel_angle[23:0], mean_angle[47:24]
    logic        o_m_axis_tuser;  // mean_valid

    angle_scoreboard sb = new();
    int  idle_cycles = 0;
    int  stall_left  = 0;
    bit  long_hold   = 0;

    spectral_angle_mapper dut (.*);

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    // receiver: random stall bursts, none near the end
    always @(posedge i_clk) begin
        if (long_hold) begin
            i_m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_m_axis_tready <= 1'b0;
        end else if (sb.n_items < QUIET_FROM && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 13);
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            sb.check_result(o_m_axis_tdata, o_m_axis_tuser);
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            idle_cycles = 0;
        else if (i_rst_n)
            idle_cycles++;
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("timeout after %0d idle cycles", idle_cycles);
            $display("FAIL spectral_angle_mapper");
            $finish;
        end
    end

    // long hold-off once, while the sender keeps going
    initial begin
        wait (sb.n_items >= 400);
        @(posedge i_clk);
        long_hold = 1;
        repeat (900) @(posedge i_clk);
        long_hold = 0;
    end

    task automatic send_item(logic [REF_W-1:0] rv, logic [REC_W-1:0] sv, logic lb, logic lp);
        if (sb.n_items < QUIET_FROM && $urandom_range(0, 4) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {7'd0, sv, rv};
        i_s_axis_tlast  <= lb;
        i_s_axis_tuser  <= lp;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        sb.note_item(rv, $signed(sv), lb, lp);
    endtask

    // style: 0 random, 1 near-parallel, 2 near-opposite, 3 zero reference
    task automatic send_pixel(int nb, logic lp, int style);
        logic [REF_W-1:0] rv;
        logic [REC_W-1:0] sv;
        int k;
        k = $urandom_range(1, 3);
        for (int b = 0; b < nb; b++) begin
            rv = $urandom_range(0, 65535);
            if ($urandom_range(0, 3) == 0) rv = rv >> $urandom_range(0, 15);
            case (style)
                1: sv = REC_W'(int'(rv) / k + $urandom_range(0, 64) - 32);
                2: sv = REC_W'(-int'(rv) + $urandom_range(0, 16) - 8);
                3: begin rv = '0; sv = $urandom_range(0, 131071); end
                default: sv = $urandom_range(0, 131071);
            endcase
            send_item(rv, sv, b == nb - 1,
                      (b == nb - 1) ? lp : ($urandom_range(0, 15) == 0));
        end
    endtask

    initial begin
        int npix;
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_s_axis_tlast  <= 1'b0;
        i_s_axis_tuser  <= 1'b0;
        i_m_axis_tready <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, full cosines, zero vectors, orthogonal, stray last_pixel
        send_item(16'hFFFF, 17'h0FFFF, 1, 0);                   // +1 cosine
        send_item(16'hFFFF, 17'h10001, 1, 0);                   // -1 cosine
        send_item(16'hFFFF, 17'h10000, 1, 0);
        send_item(16'h0000, 17'h10000, 1, 0);                   // zero reference
        send_item(16'h1234, 17'h00000, 1, 0);                   // zero reconstruction
        send_item(16'h0001, 17'h00000, 0, 1);                   // last_pixel ignored
        send_item(16'h0000, 17'h00001, 1, 0);                   // orthogonal: 90
        send_item(16'h0003, 17'h00004, 0, 0);
        send_item(16'h0004, 17'h1FFFD, 1, 0);
        send_item(16'h8000, 17'h08000, 0, 0);
        send_item(16'h0001, 17'h1FFFF, 1, 1);                   // end of image
        send_item(16'h5555, 17'h0AAAA, 1, 1);                   // single-pixel image
        send_item(16'hAAAA, 17'h15555, 1, 1);
        send_item(16'h0000, 17'h00000, 1, 1);                   // all zero

        // drain before the random part
        i_s_axis_tvalid <= 1'b0;
        wait (sb.pending_q.size() == 0);
        @(posedge i_clk);

        while (sb.n_items < N_ITEMS) begin
            npix = $urandom_range(1, 6);
            for (int p = 0; p < npix; p++)
                send_pixel(($urandom_range(0, 15) == 0) ? $urandom_range(9, 40)
                                                         : $urandom_range(1, 8),
                           p == npix - 1, $urandom_range(0, 9) < 4 ? 0 :
                           $urandom_range(0, 9) < 7 ? 1 : $urandom_range(2, 3));
        end
        i_s_axis_tvalid <= 1'b0;

        wait (sb.pending_q.size() == 0);
        repeat (400) @(posedge i_clk);
        $display("covered %0d band items, %0d pixel results, %0d images",
                 sb.n_items, sb.n_results, sb.n_images);
        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("PASS spectral_angle_mapper");
        end else begin
            $display("FAIL spectral_angle_mapper");
        end
        $finish;
    end
endmodule

[sim.f]
design/sam_pkg.sv
design/sam_front.sv
design/sam_queue.sv
design/sam_back.sv
design/spectral_angle_mapper.sv
dv/tb.sv
